// ----- design/maximal_rectangle_binary_matrix_defines.svh -----
`ifndef MAXIMAL_RECTANGLE_BINARY_MATRIX_DEFINES_SVH
`define MAXIMAL_RECTANGLE_BINARY_MATRIX_DEFINES_SVH

// Same-cycle implication check, held off while reset is asserted
`define MRBM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication check, held off while reset is asserted
`define MRBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- design/mrbm_pkg.sv -----
package mrbm_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 1024;

    localparam int COL_W  = $clog2(MAX_COLS);        // column index
    localparam int CNT_W  = $clog2(MAX_COLS + 1);    // column count, stack depth
    localparam int HGT_W  = $clog2(MAX_ROWS + 1);    // run height
    localparam int AREA_W = 17;
    localparam int PROD_W = HGT_W + CNT_W;
    localparam int ROW_W  = 64;
    localparam int OUT_DATA_W = ((2 * AREA_W + 7) / 8) * 8;

    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // take a new row, restart the scan
        logic pop;      // pop the stack top and score its rectangle
        logic push;     // push the current column and advance
        logic finish;   // publish the row result
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic can_pop;  // current height is below the stack top
        logic col_end;  // scan index has passed the last active column
        logic out_busy; // result register still holds an untaken beat
    } stat_t;

endpackage

// ----- design/mrbm_ctrl.sv -----
module mrbm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  mrbm_pkg::stat_t stat,
    output mrbm_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequence one row: accept, stack scan, publish
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.can_pop) begin
                    cmd.pop = 1'b1;
                end else if (!stat.col_end) begin
                    cmd.push = 1'b1;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/mrbm_dp.sv -----
module mrbm_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mrbm_pkg::cmd_t                     cmd,
    output mrbm_pkg::stat_t                    stat,
    input  logic                               cfg_we,
    input  logic [mrbm_pkg::CNT_W-1:0]         cfg_cols,
    input  logic [mrbm_pkg::ROW_W-1:0]         row_bits,
    input  logic                               last_row,
    output logic [mrbm_pkg::AREA_W-1:0]        row_best_area,
    output logic [mrbm_pkg::AREA_W-1:0]        best_area_so_far,
    output logic                               matrix_done,
    output logic                               out_valid,
    input  logic                               out_ready
);

    localparam int CW = mrbm_pkg::COL_W;
    localparam int NW = mrbm_pkg::CNT_W;
    localparam int HW = mrbm_pkg::HGT_W;
    localparam int AW = mrbm_pkg::AREA_W;
    localparam int PW = mrbm_pkg::PROD_W;
    localparam int MC = mrbm_pkg::MAX_COLS;

    typedef struct packed {
        logic [CW-1:0] idx;
        logic [HW-1:0] hgt;
    } entry_t;

    // Configuration and row context
    logic [NW-1:0]            cols_reg;
    logic [mrbm_pkg::ROW_W-1:0] row_reg;
    logic                     last_reg;
    logic [NW-1:0]            n_reg;
    logic [NW-1:0]            i_reg;
    logic [NW-1:0]            i_next;

    // Height store with per-column valid bits
    logic [HW-1:0]            hmem [MC];
    logic [HW-1:0]            h_rdata_reg;
    logic [MC-1:0]            hvalid_reg;
    logic [MC-1:0]            keep_mask;

    // Index stack: top in registers, the rest in memory
    entry_t                   smem [MC];
    entry_t                   s_rdata_reg;
    entry_t                   top_reg;
    entry_t                   copy_reg;
    logic                     bypass_reg;
    logic [NW-1:0]            depth_reg;
    logic [NW-1:0]            depth_next;
    logic [NW-1:0]            s_addr_full;
    logic [NW-1:0]            depth_m1;

    // Area scoring
    logic [PW-1:0]            prod_reg;
    logic                     prod_valid_reg;
    logic [AW-1:0]            best_reg;
    logic [AW-1:0]            run_reg;
    logic [AW-1:0]            prod_clamp;
    logic [AW-1:0]            so_far;

    // Result register
    logic [AW-1:0]            out_row_reg;
    logic [AW-1:0]            out_far_reg;
    logic                     out_last_reg;
    logic                     out_valid_reg;

    logic [NW-1:0]            n_eff;
    logic                     col_end;
    logic [HW-1:0]            old_h;
    logic [HW-1:0]            inc_h;
    logic [HW-1:0]            cur_h;
    entry_t                   below;
    logic [NW-1:0]            width;

    // Clamp the column count to the array size
    assign n_eff = (cols_reg > NW'(MC)) ? NW'(MC) : cols_reg;

    always_comb begin
        for (int c = 0; c < MC; c++) begin
            keep_mask[c] = (NW'(c) < n_eff);
        end
    end

    // Current column height, or zero at the closing position
    assign col_end = (i_reg == n_reg);
    assign old_h   = hvalid_reg[i_reg[CW-1:0]] ? h_rdata_reg : '0;
    assign inc_h   = (old_h >= HW'(mrbm_pkg::MAX_ROWS)) ? HW'(mrbm_pkg::MAX_ROWS)
                                                       : old_h + HW'(1);
    assign cur_h   = (!col_end && row_reg[i_reg[CW-1:0]]) ? inc_h : '0;

    assign below   = bypass_reg ? copy_reg : s_rdata_reg;
    assign width   = (depth_reg > NW'(1)) ? (i_reg - {1'b0, below.idx} - NW'(1)) : i_reg;

    assign stat.can_pop  = (depth_reg != '0) && (cur_h < top_reg.hgt);
    assign stat.col_end  = col_end;
    assign stat.out_busy = out_valid_reg && !out_ready;

    always_comb begin
        i_next     = i_reg;
        depth_next = depth_reg;
        if (cmd.load) begin
            i_next     = '0;
            depth_next = '0;
        end else if (cmd.push) begin
            i_next     = i_reg + NW'(1);
            depth_next = depth_reg + NW'(1);
        end else if (cmd.pop) begin
            depth_next = depth_reg - NW'(1);
        end
    end

    assign s_addr_full = depth_next - NW'(2);
    assign depth_m1    = depth_reg - NW'(1);

    // Height memory: read ahead at the next column, write on push
    always_ff @(posedge aclk) begin
        h_rdata_reg <= hmem[i_next[CW-1:0]];
        if (cmd.push) begin
            hmem[i_reg[CW-1:0]] <= cur_h;
        end
    end

    // Stack memory: keep the entry under the top on the read port
    always_ff @(posedge aclk) begin
        s_rdata_reg <= smem[s_addr_full[CW-1:0]];
        if (cmd.push && depth_reg != '0) begin
            smem[depth_m1[CW-1:0]] <= top_reg;
        end
    end

    // Stack top, bypass copy and row context
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            row_reg    <= row_bits;
            last_reg   <= last_row;
            n_reg      <= n_eff;
            bypass_reg <= 1'b0;
        end else if (cmd.push) begin
            copy_reg   <= top_reg;
            bypass_reg <= (depth_reg != '0);
            top_reg    <= '{idx: i_reg[CW-1:0], hgt: cur_h};
        end else if (cmd.pop) begin
            top_reg    <= below;
            bypass_reg <= 1'b0;
        end
        if (cmd.pop) begin
            prod_reg <= PW'(top_reg.hgt) * PW'(width);
        end
    end

    assign prod_clamp = (prod_reg > PW'(mrbm_pkg::AREA_MAX)) ? mrbm_pkg::AREA_MAX
                                                             : prod_reg[AW-1:0];
    assign so_far     = (best_reg > run_reg) ? best_reg : run_reg;

    // Best area of this row
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            best_reg <= '0;
        end else if (prod_valid_reg && prod_clamp > best_reg) begin
            best_reg <= prod_clamp;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_row_reg  <= best_reg;
            out_far_reg  <= so_far;
            out_last_reg <= last_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg       <= NW'(MC);
            hvalid_reg     <= '0;
            depth_reg      <= '0;
            i_reg          <= '0;
            prod_valid_reg <= 1'b0;
            run_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                cols_reg <= cfg_cols;
            end
            depth_reg      <= depth_next;
            i_reg          <= i_next;
            prod_valid_reg <= cmd.pop;
            // Drop heights of unused columns, mark written ones, clear at matrix end
            if (cmd.load) begin
                hvalid_reg <= hvalid_reg & keep_mask;
            end else if (cmd.push) begin
                hvalid_reg[i_reg[CW-1:0]] <= 1'b1;
            end else if (cmd.finish && last_reg) begin
                hvalid_reg <= '0;
            end
            if (cmd.finish) begin
                run_reg <= last_reg ? '0 : so_far;
            end
            // Hold the result until the beat is taken
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign row_best_area    = out_row_reg;
    assign best_area_so_far = out_far_reg;
    assign matrix_done      = out_last_reg;
    assign out_valid        = out_valid_reg;

endmodule

// ----- design/maximal_rectangle_binary_matrix.sv -----
// Largest all-ones rectangle of a binary matrix that arrives one row per input beat
// (bit c of the row is column c; tlast marks the final row). Each column keeps the
// height of consecutive ones ending at the current row, and a monotonic index stack
// scans that histogram once per row, one push or one pop per clock. Each result beat
// carries the row's best area and the running best of the matrix; after the final
// row the heights and the running best clear. A finished result waits in an output
// register, so the next row is taken while it is pending. The column count register
// is written through the cfg channel and applies from the next row; the user must
// write it only while the block is idle, as the block itself does not enforce this.
`include "maximal_rectangle_binary_matrix_defines.svh"

module maximal_rectangle_binary_matrix (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Column count register
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mrbm_pkg::CNT_W-1:0]          cfg_data,     // active_columns
    // Row input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mrbm_pkg::ROW_W-1:0]          s_tdata,      // row_bits
    input  logic                                s_tlast,      // last_row
    // Result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mrbm_pkg::OUT_DATA_W-1:0]     m_tdata,      // row_best_area, best_area_so_far
    output logic                                m_tlast       // matrix_done
);

    mrbm_pkg::cmd_t                 cmd;
    mrbm_pkg::stat_t                stat;
    logic [mrbm_pkg::AREA_W-1:0]    row_best_area;
    logic [mrbm_pkg::AREA_W-1:0]    best_area_so_far;

    assign cfg_ready = 1'b1;

    mrbm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mrbm_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_valid),
        .cfg_cols         (cfg_data),
        .row_bits         (s_tdata),
        .last_row         (s_tlast),
        .row_best_area    (row_best_area),
        .best_area_so_far (best_area_so_far),
        .matrix_done      (m_tlast),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready)
    );

    // Pack result beat, zero fill to whole bytes
    assign m_tdata = {{(mrbm_pkg::OUT_DATA_W - 2 * mrbm_pkg::AREA_W){1'b0}},
                      best_area_so_far, row_best_area};

    // The running best never falls below the row best it includes
    `MRBM_ASSERT_NOW(a_best_order, aclk, aresetn, m_tvalid, best_area_so_far >= row_best_area)
    // An accepted row keeps the input closed for the scan
    `MRBM_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // A new result only comes out of a scan, never from idle
    `MRBM_ASSERT_NOW(a_result_from_scan, aclk, aresetn, $rose(m_tvalid), $past(!s_tready))

endmodule
